FILE: rtl/rmj_pkg.sv
// ----------------------------------------------------------------------------
// rmj_pkg
// Shared widths, latencies, queue entry type and output packing for the
// radar measurement Jacobian block.
// ----------------------------------------------------------------------------
package rmj_pkg;

   localparam int DATA_W    = 32;
   localparam int WIDE_W    = 64;
   localparam int BIG_W     = 192;
   localparam int DIV_N_W   = 224;
   localparam int DIV_Q_W   = 64;
   localparam int DIV_STEPS = 64;
   localparam int DIV_LAT   = DIV_STEPS + 1;
   localparam int SQ_STEPS  = 32;
   localparam int BACK_LAT  = DIV_LAT + SQ_STEPS;
   localparam int FRONT_LAT = 6;
   localparam int Q_DEPTH   = 4;
   localparam int Q_PTR_W   = $clog2(Q_DEPTH);
   localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
   localparam int N_ENTRY   = 6;

   // entry positions in the sign vector
   localparam int E_RANGE_X   = 0;
   localparam int E_RANGE_Y   = 1;
   localparam int E_BEARING_X = 2;
   localparam int E_BEARING_Y = 3;
   localparam int E_RATE_X    = 4;
   localparam int E_RATE_Y    = 5;

   typedef struct packed {
      logic [WIDE_W-1:0]  sq_x;
      logic [WIDE_W-1:0]  sq_y;
      logic [DATA_W-1:0]  apx;
      logic [DATA_W-1:0]  apy;
      logic [WIDE_W-1:0]  s;
      logic [BIG_W-1:0]   s3;
      logic [BIG_W-1:0]   qx;
      logic [BIG_W-1:0]   qy;
      logic [N_ENTRY-1:0] neg;
      logic               zero;
   } job_type;

   typedef struct packed {
      logic [N_ENTRY-1:0] neg;
      logic               zero;
   } side_type;

   // sign and magnitude to saturated two's complement
   function automatic logic [DATA_W-1:0] pack_sat(input logic neg,
                                                  input logic [DATA_W-1:0] mag);
      logic [DATA_W-1:0] r;
      if (neg) begin
         r = mag[DATA_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : (~mag + 1'b1);
      end else begin
         r = mag[DATA_W-1] ? {1'b0, {(DATA_W-1){1'b1}}} : mag;
      end
      return r;
   endfunction

   function automatic logic [DATA_W-1:0] cap_mag(input logic [DIV_Q_W-1:0] q);
      logic [DATA_W-1:0] r;
      r = (q[DIV_Q_W-1:DATA_W] != '0) ? {DATA_W{1'b1}} : q[DATA_W-1:0];
      return r;
   endfunction

endpackage

FILE: rtl/radar_measurement_jacobian.sv
// ----------------------------------------------------------------------------
// radar_measurement_jacobian
// Radar range, bearing and range-rate Jacobian entries from a predicted
// state, exact to Q16.16 truncation with saturation.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  req_      in         req_valid / req_ready   position x/y, velocity x/y
//  rsp_      out        rsp_valid / rsp_ready   six entries, divide_by_zero
//
//  one item per cycle sustained while results are taken; path: 6 multiplier
//  stages, the queue, 65 divider stages, 32 root stages, output register
//  divider and root pipelines set the latency, one quotient or root bit a stage
//  reset empties the queue and clears the valid lines, nothing else
//  a held result stalls the back end; the front end stalls only on a full queue
// ----------------------------------------------------------------------------
module radar_measurement_jacobian (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rmj_pkg::DATA_W-1:0]  req_position_x,
   input  logic [rmj_pkg::DATA_W-1:0]  req_position_y,
   input  logic [rmj_pkg::DATA_W-1:0]  req_velocity_x,
   input  logic [rmj_pkg::DATA_W-1:0]  req_velocity_y,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_range_by_px,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_range_by_py,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_bearing_by_px,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_bearing_by_py,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_rate_by_px,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_rate_by_py,
   output logic                        rsp_divide_by_zero
);

   logic             q_push, q_pop, q_empty, q_full;
   rmj_pkg::job_type q_push_job, q_head_job;

   assign req_ready = !q_full;

   rmj_front u_front (
      .clock          (clock),
      .reset          (reset),
      .en             (req_ready),
      .req_valid      (req_valid),
      .req_position_x (req_position_x),
      .req_position_y (req_position_y),
      .req_velocity_x (req_velocity_x),
      .req_velocity_y (req_velocity_y),
      .push           (q_push),
      .push_job       (q_push_job)
   );

   rmj_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .empty    (q_empty),
      .full     (q_full)
   );

   rmj_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_job           (q_head_job),
      .empty              (q_empty),
      .pop                (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_range_by_px    (rsp_range_by_px),
      .rsp_range_by_py    (rsp_range_by_py),
      .rsp_bearing_by_px  (rsp_bearing_by_px),
      .rsp_bearing_by_py  (rsp_bearing_by_py),
      .rsp_rate_by_px     (rsp_rate_by_px),
      .rsp_rate_by_py     (rsp_rate_by_py),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("queue written while full");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_empty |-> !q_pop)
      else $error("queue read while empty");

   a_origin_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |->
         (rsp_range_by_px == '0 && rsp_range_by_py == '0 &&
          rsp_bearing_by_px == '0 && rsp_bearing_by_py == '0 &&
          rsp_rate_by_px == '0 && rsp_rate_by_py == '0))
      else $error("origin result not cleared");

   a_range_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($signed(rsp_range_by_px) <= 32'sd65536 &&
                     $signed(rsp_range_by_px) >= -32'sd65536))
      else $error("range entry beyond one");

endmodule

FILE: rtl/rmj_div.sv
// ----------------------------------------------------------------------------
// rmj_div
// Pipelined restoring divider, one quotient bit per stage, quotient capped
// at all ones when it does not fit.
// ----------------------------------------------------------------------------
module rmj_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [rmj_pkg::DIV_N_W-1:0]  num,
   input  logic [rmj_pkg::BIG_W-1:0]    den,
   output logic [rmj_pkg::DIV_Q_W-1:0]  quo
);

   localparam int NS = rmj_pkg::DIV_STEPS;
   localparam int BW = rmj_pkg::BIG_W;
   localparam int QW = rmj_pkg::DIV_Q_W;

   logic [BW-1:0] rem_ff [0:NS];
   logic [BW-1:0] rem_in [0:NS];
   logic [QW-1:0] low_ff [0:NS];
   logic [QW-1:0] low_in [0:NS];
   logic [QW-1:0] quo_ff [0:NS];
   logic [QW-1:0] quo_in [0:NS];
   logic [BW-1:0] den_ff [0:NS];
   logic [BW-1:0] den_in [0:NS];
   logic          ovf_ff [0:NS];
   logic          ovf_in [0:NS];

   always_comb begin
      logic [BW-1:0] top;
      logic [BW:0]   trial;
      logic          ge;
      top       = BW'(num[rmj_pkg::DIV_N_W-1:QW]);
      // upper part not below the divisor means the quotient overflows
      ovf_in[0] = (top >= den);
      rem_in[0] = ovf_in[0] ? '0 : top;
      low_in[0] = num[QW-1:0];
      quo_in[0] = '0;
      den_in[0] = den;
      for (int k = 1; k <= NS; k++) begin
         trial     = {rem_ff[k-1], low_ff[k-1][QW-1]};
         ge        = (trial >= {1'b0, den_ff[k-1]});
         rem_in[k] = ge ? BW'(trial - {1'b0, den_ff[k-1]}) : trial[BW-1:0];
         low_in[k] = {low_ff[k-1][QW-2:0], 1'b0};
         quo_in[k] = {quo_ff[k-1][QW-2:0], ge};
         den_in[k] = den_ff[k-1];
         ovf_in[k] = ovf_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= NS; k++) begin
            rem_ff[k] <= rem_in[k];
            low_ff[k] <= low_in[k];
            quo_ff[k] <= quo_in[k];
            den_ff[k] <= den_in[k];
            ovf_ff[k] <= ovf_in[k];
         end
      end
   end

   assign quo = ovf_ff[NS] ? {QW{1'b1}} : quo_ff[NS];

endmodule

FILE: rtl/rmj_sqrt.sv
// ----------------------------------------------------------------------------
// rmj_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rmj_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [rmj_pkg::WIDE_W-1:0]  rad,
   output logic [rmj_pkg::DATA_W-1:0]  root
);

   localparam int NS = rmj_pkg::SQ_STEPS;
   localparam int WW = rmj_pkg::WIDE_W;

   logic [WW-1:0] op_ff  [0:NS-1];
   logic [WW-1:0] op_in  [0:NS-1];
   logic [WW-1:0] res_ff [0:NS-1];
   logic [WW-1:0] res_in [0:NS-1];

   always_comb begin
      logic [WW-1:0] op_src;
      logic [WW-1:0] res_src;
      logic [WW-1:0] one;
      logic [WW-1:0] trial;
      for (int k = 0; k < NS; k++) begin
         op_src  = (k == 0) ? rad : op_ff[(k == 0) ? 0 : k-1];
         res_src = (k == 0) ? '0  : res_ff[(k == 0) ? 0 : k-1];
         one     = WW'(1) << (WW - 2 - 2*k);
         trial   = res_src + one;
         if (op_src >= trial) begin
            op_in[k]  = op_src - trial;
            res_in[k] = (res_src >> 1) + one;
         end else begin
            op_in[k]  = op_src;
            res_in[k] = res_src >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < NS; k++) begin
            op_ff[k]  <= op_in[k];
            res_ff[k] <= res_in[k];
         end
      end
   end

   assign root = res_ff[NS-1][rmj_pkg::DATA_W-1:0];

endmodule

FILE: rtl/rmj_front.sv
// ----------------------------------------------------------------------------
// rmj_front
// Front end: takes the state, forms squared distance, its cube, the cross
// term and the squared numerators in a six stage multiplier pipeline.
// ----------------------------------------------------------------------------
module rmj_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        req_valid,
   input  logic [rmj_pkg::DATA_W-1:0]  req_position_x,
   input  logic [rmj_pkg::DATA_W-1:0]  req_position_y,
   input  logic [rmj_pkg::DATA_W-1:0]  req_velocity_x,
   input  logic [rmj_pkg::DATA_W-1:0]  req_velocity_y,
   output logic                        push,
   output rmj_pkg::job_type            push_job
);

   localparam int DW = rmj_pkg::DATA_W;
   localparam int WW = rmj_pkg::WIDE_W;
   localparam int BW = rmj_pkg::BIG_W;
   localparam int NE = rmj_pkg::N_ENTRY;

   logic [rmj_pkg::FRONT_LAT-1:0] vld_ff;

   // stage 1
   logic [DW-1:0]        p1_apx_ff, p1_apx_in, p1_apy_ff, p1_apy_in;
   logic [WW-1:0]        p1_sqx_ff, p1_sqx_in, p1_sqy_ff, p1_sqy_in;
   logic signed [WW-1:0] p1_t1_ff, p1_t1_in, p1_t2_ff, p1_t2_in;
   logic                 p1_sx_ff, p1_sx_in, p1_sy_ff, p1_sy_in, p1_yp_ff, p1_yp_in;
   // stage 2
   logic [DW-1:0]        p2_apx_ff, p2_apy_ff;
   logic [WW-1:0]        p2_sqx_ff, p2_sqy_ff, p2_s_ff, p2_s_in, p2_dm_ff, p2_dm_in;
   logic [NE-1:0]        p2_neg_ff, p2_neg_in;
   // stage 3
   logic [DW-1:0]        p3_apx_ff, p3_apy_ff;
   logic [WW-1:0]        p3_sqx_ff, p3_sqy_ff, p3_s_ff;
   logic [WW-1:0]        p3_ss_ff [0:1][0:1];
   logic [WW-1:0]        p3_ss_in [0:1][0:1];
   logic [WW-1:0]        p3_tx_ff [0:1];
   logic [WW-1:0]        p3_tx_in [0:1];
   logic [WW-1:0]        p3_ty_ff [0:1];
   logic [WW-1:0]        p3_ty_in [0:1];
   logic [NE-1:0]        p3_neg_ff;
   logic                 p3_zero_ff;
   // stage 4
   logic [DW-1:0]        p4_apx_ff, p4_apy_ff;
   logic [WW-1:0]        p4_sqx_ff, p4_sqy_ff, p4_s_ff;
   logic [2*WW-1:0]      p4_s2_ff, p4_s2_in;
   logic [3*DW-1:0]      p4_tx_ff, p4_tx_in, p4_ty_ff, p4_ty_in;
   logic [NE-1:0]        p4_neg_ff;
   logic                 p4_zero_ff;
   // stage 5
   logic [DW-1:0]        p5_apx_ff, p5_apy_ff;
   logic [WW-1:0]        p5_sqx_ff, p5_sqy_ff, p5_s_ff;
   logic [WW-1:0]        p5_s3_ff [0:3][0:1];
   logic [WW-1:0]        p5_s3_in [0:3][0:1];
   logic [WW-1:0]        p5_xx_ff [0:2][0:2];
   logic [WW-1:0]        p5_xx_in [0:2][0:2];
   logic [WW-1:0]        p5_yy_ff [0:2][0:2];
   logic [WW-1:0]        p5_yy_in [0:2][0:2];
   logic [NE-1:0]        p5_neg_ff;
   logic                 p5_zero_ff;
   // stage 6
   rmj_pkg::job_type     p6_job_ff, p6_job_in;

   always_comb begin
      logic signed [DW-1:0] px, py, vx, vy;
      px = $signed(req_position_x);
      py = $signed(req_position_y);
      vx = $signed(req_velocity_x);
      vy = $signed(req_velocity_y);
      p1_apx_in = px[DW-1] ? (~req_position_x + 1'b1) : req_position_x;
      p1_apy_in = py[DW-1] ? (~req_position_y + 1'b1) : req_position_y;
      p1_sqx_in = WW'(p1_apx_in) * WW'(p1_apx_in);
      p1_sqy_in = WW'(p1_apy_in) * WW'(p1_apy_in);
      p1_t1_in  = WW'(vx) * WW'(py);
      p1_t2_in  = WW'(vy) * WW'(px);
      p1_sx_in  = px[DW-1];
      p1_sy_in  = py[DW-1];
      p1_yp_in  = !py[DW-1] && (req_position_y != '0);
   end

   always_comb begin
      logic [WW:0] d;
      logic [WW:0] dabs;
      logic        dneg;
      p2_s_in  = p1_sqx_ff + p1_sqy_ff;
      d        = {p1_t1_ff[WW-1], p1_t1_ff} - {p1_t2_ff[WW-1], p1_t2_ff};
      dneg     = d[WW];
      dabs     = dneg ? (~d + 1'b1) : d;
      p2_dm_in = dabs[WW-1:0];
      p2_neg_in[rmj_pkg::E_RANGE_X]   = p1_sx_ff;
      p2_neg_in[rmj_pkg::E_RANGE_Y]   = p1_sy_ff;
      p2_neg_in[rmj_pkg::E_BEARING_X] = p1_yp_ff;
      p2_neg_in[rmj_pkg::E_BEARING_Y] = p1_sx_ff;
      p2_neg_in[rmj_pkg::E_RATE_X]    = p1_sy_ff ^ dneg;
      p2_neg_in[rmj_pkg::E_RATE_Y]    = !(p1_sx_ff ^ dneg);
   end

   // limb partial products, each one 32 by 32
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            p3_ss_in[i][j] = WW'(p2_s_ff[DW*i +: DW]) * WW'(p2_s_ff[DW*j +: DW]);
         end
         p3_tx_in[i] = WW'(p2_apx_ff) * WW'(p2_dm_ff[DW*i +: DW]);
         p3_ty_in[i] = WW'(p2_apy_ff) * WW'(p2_dm_ff[DW*i +: DW]);
      end
   end

   always_comb begin
      p4_s2_in = '0;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            p4_s2_in = p4_s2_in + ((2*WW)'(p3_ss_ff[i][j]) << (DW*(i+j)));
         end
      end
      p4_tx_in = (3*DW)'(p3_tx_ff[0]) + ((3*DW)'(p3_tx_ff[1]) << DW);
      p4_ty_in = (3*DW)'(p3_ty_ff[0]) + ((3*DW)'(p3_ty_ff[1]) << DW);
   end

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 2; j++) begin
            p5_s3_in[i][j] = WW'(p4_s2_ff[DW*i +: DW]) * WW'(p4_s_ff[DW*j +: DW]);
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p5_xx_in[i][j] = WW'(p4_tx_ff[DW*i +: DW]) * WW'(p4_tx_ff[DW*j +: DW]);
            p5_yy_in[i][j] = WW'(p4_ty_ff[DW*i +: DW]) * WW'(p4_ty_ff[DW*j +: DW]);
         end
      end
   end

   always_comb begin
      p6_job_in.sq_x = p5_sqx_ff;
      p6_job_in.sq_y = p5_sqy_ff;
      p6_job_in.apx  = p5_apx_ff;
      p6_job_in.apy  = p5_apy_ff;
      p6_job_in.s    = p5_s_ff;
      p6_job_in.neg  = p5_neg_ff;
      p6_job_in.zero = p5_zero_ff;
      p6_job_in.s3   = '0;
      p6_job_in.qx   = '0;
      p6_job_in.qy   = '0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 2; j++) begin
            p6_job_in.s3 = p6_job_in.s3 + (BW'(p5_s3_ff[i][j]) << (DW*(i+j)));
         end
      end
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            p6_job_in.qx = p6_job_in.qx + (BW'(p5_xx_ff[i][j]) << (DW*(i+j)));
            p6_job_in.qy = p6_job_in.qy + (BW'(p5_yy_ff[i][j]) << (DW*(i+j)));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[rmj_pkg::FRONT_LAT-2:0], req_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_apx_ff <= p1_apx_in;
         p1_apy_ff <= p1_apy_in;
         p1_sqx_ff <= p1_sqx_in;
         p1_sqy_ff <= p1_sqy_in;
         p1_t1_ff  <= p1_t1_in;
         p1_t2_ff  <= p1_t2_in;
         p1_sx_ff  <= p1_sx_in;
         p1_sy_ff  <= p1_sy_in;
         p1_yp_ff  <= p1_yp_in;

         p2_apx_ff <= p1_apx_ff;
         p2_apy_ff <= p1_apy_ff;
         p2_sqx_ff <= p1_sqx_ff;
         p2_sqy_ff <= p1_sqy_ff;
         p2_s_ff   <= p2_s_in;
         p2_dm_ff  <= p2_dm_in;
         p2_neg_ff <= p2_neg_in;

         p3_apx_ff  <= p2_apx_ff;
         p3_apy_ff  <= p2_apy_ff;
         p3_sqx_ff  <= p2_sqx_ff;
         p3_sqy_ff  <= p2_sqy_ff;
         p3_s_ff    <= p2_s_ff;
         p3_neg_ff  <= p2_neg_ff;
         p3_zero_ff <= (p2_s_ff == '0);
         for (int i = 0; i < 2; i++) begin
            for (int j = 0; j < 2; j++) begin
               p3_ss_ff[i][j] <= p3_ss_in[i][j];
            end
            p3_tx_ff[i] <= p3_tx_in[i];
            p3_ty_ff[i] <= p3_ty_in[i];
         end

         p4_apx_ff  <= p3_apx_ff;
         p4_apy_ff  <= p3_apy_ff;
         p4_sqx_ff  <= p3_sqx_ff;
         p4_sqy_ff  <= p3_sqy_ff;
         p4_s_ff    <= p3_s_ff;
         p4_neg_ff  <= p3_neg_ff;
         p4_zero_ff <= p3_zero_ff;
         p4_s2_ff   <= p4_s2_in;
         p4_tx_ff   <= p4_tx_in;
         p4_ty_ff   <= p4_ty_in;

         p5_apx_ff  <= p4_apx_ff;
         p5_apy_ff  <= p4_apy_ff;
         p5_sqx_ff  <= p4_sqx_ff;
         p5_sqy_ff  <= p4_sqy_ff;
         p5_s_ff    <= p4_s_ff;
         p5_neg_ff  <= p4_neg_ff;
         p5_zero_ff <= p4_zero_ff;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 2; j++) begin
               p5_s3_ff[i][j] <= p5_s3_in[i][j];
            end
         end
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               p5_xx_ff[i][j] <= p5_xx_in[i][j];
               p5_yy_ff[i][j] <= p5_yy_in[i][j];
            end
         end

         p6_job_ff <= p6_job_in;
      end
   end

   assign push     = en && vld_ff[rmj_pkg::FRONT_LAT-1];
   assign push_job = p6_job_ff;

endmodule

FILE: rtl/rmj_queue.sv
// ----------------------------------------------------------------------------
// rmj_queue
// Short queue between the front end and the divide and root back end.
// ----------------------------------------------------------------------------
module rmj_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  rmj_pkg::job_type push_job,
   input  logic             pop,
   output rmj_pkg::job_type head_job,
   output logic             empty,
   output logic             full
);

   rmj_pkg::job_type               job_ff [0:rmj_pkg::Q_DEPTH-1];
   logic [rmj_pkg::Q_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [rmj_pkg::Q_CNT_W-1:0]    cnt_ff, cnt_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + rmj_pkg::Q_CNT_W'(push) - rmj_pkg::Q_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         job_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job = job_ff[rd_ptr_ff];
   assign empty    = (cnt_ff == '0);
   assign full     = (cnt_ff == rmj_pkg::Q_CNT_W'(rmj_pkg::Q_DEPTH));

endmodule

FILE: rtl/rmj_back.sv
// ----------------------------------------------------------------------------
// rmj_back
// Back end: six pipelined dividers, four pipelined roots and the output
// register with sign, saturation and the origin case.
// ----------------------------------------------------------------------------
module rmj_back (
   input  logic                        clock,
   input  logic                        reset,
   input  rmj_pkg::job_type            head_job,
   input  logic                        empty,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_range_by_px,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_range_by_py,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_bearing_by_px,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_bearing_by_py,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_rate_by_px,
   output logic [rmj_pkg::DATA_W-1:0]  rsp_rate_by_py,
   output logic                        rsp_divide_by_zero
);

   localparam int DW = rmj_pkg::DATA_W;
   localparam int NW = rmj_pkg::DIV_N_W;
   localparam int BW = rmj_pkg::BIG_W;
   localparam int QW = rmj_pkg::DIV_Q_W;
   localparam int BL = rmj_pkg::BACK_LAT;
   localparam int SL = rmj_pkg::SQ_STEPS;
   localparam int NE = rmj_pkg::N_ENTRY;

   logic en;
   logic [BL-1:0]        vld_ff;
   rmj_pkg::side_type    side_ff [0:BL-1];
   logic [DW-1:0]        magx_ff [0:SL-1];
   logic [DW-1:0]        magy_ff [0:SL-1];
   logic [NW-1:0]        num [0:NE-1];
   logic [BW-1:0]        den [0:NE-1];
   logic [QW-1:0]        quo [0:NE-1];
   logic [DW-1:0]        root_rx, root_ry, root_tx, root_ty;

   logic                 out_vld_ff;
   logic [DW-1:0]        o_rx_ff, o_ry_ff, o_bx_ff, o_by_ff, o_tx_ff, o_ty_ff;
   logic [DW-1:0]        o_rx_in, o_ry_in, o_bx_in, o_by_in, o_tx_in, o_ty_in;
   logic                 o_zero_ff;
   rmj_pkg::side_type    last_side;

   assign en  = !out_vld_ff || rsp_ready;
   assign pop = en && !empty;

   // numerators scaled so each quotient is the squared or plain entry value
   always_comb begin
      num[rmj_pkg::E_RANGE_X]   = NW'({head_job.sq_x, 32'd0});
      num[rmj_pkg::E_RANGE_Y]   = NW'({head_job.sq_y, 32'd0});
      num[rmj_pkg::E_BEARING_X] = NW'({head_job.apy, 32'd0});
      num[rmj_pkg::E_BEARING_Y] = NW'({head_job.apx, 32'd0});
      num[rmj_pkg::E_RATE_X]    = {head_job.qy, 32'd0};
      num[rmj_pkg::E_RATE_Y]    = {head_job.qx, 32'd0};
      for (int i = 0; i < NE; i++) begin
         den[i] = BW'(head_job.s);
      end
      den[rmj_pkg::E_RATE_X] = head_job.s3;
      den[rmj_pkg::E_RATE_Y] = head_job.s3;
   end

   genvar g;
   generate
      for (g = 0; g < NE; g++) begin : g_div
         rmj_div u_div (
            .clock (clock),
            .en    (en),
            .num   (num[g]),
            .den   (den[g]),
            .quo   (quo[g])
         );
      end
   endgenerate

   rmj_sqrt u_sqrt_rx (.clock(clock), .en(en), .rad(quo[rmj_pkg::E_RANGE_X]), .root(root_rx));
   rmj_sqrt u_sqrt_ry (.clock(clock), .en(en), .rad(quo[rmj_pkg::E_RANGE_Y]), .root(root_ry));
   rmj_sqrt u_sqrt_tx (.clock(clock), .en(en), .rad(quo[rmj_pkg::E_RATE_X]),  .root(root_tx));
   rmj_sqrt u_sqrt_ty (.clock(clock), .en(en), .rad(quo[rmj_pkg::E_RATE_Y]),  .root(root_ty));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[BL-2:0], pop};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0].neg  <= head_job.neg;
         side_ff[0].zero <= head_job.zero;
         for (int k = 1; k < BL; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
         // bearing entries skip the root, so they wait alongside it
         magx_ff[0] <= rmj_pkg::cap_mag(quo[rmj_pkg::E_BEARING_X]);
         magy_ff[0] <= rmj_pkg::cap_mag(quo[rmj_pkg::E_BEARING_Y]);
         for (int k = 1; k < SL; k++) begin
            magx_ff[k] <= magx_ff[k-1];
            magy_ff[k] <= magy_ff[k-1];
         end
      end
   end

   assign last_side = side_ff[BL-1];

   always_comb begin
      o_rx_in = rmj_pkg::pack_sat(last_side.neg[rmj_pkg::E_RANGE_X], root_rx);
      o_ry_in = rmj_pkg::pack_sat(last_side.neg[rmj_pkg::E_RANGE_Y], root_ry);
      o_bx_in = rmj_pkg::pack_sat(last_side.neg[rmj_pkg::E_BEARING_X], magx_ff[SL-1]);
      o_by_in = rmj_pkg::pack_sat(last_side.neg[rmj_pkg::E_BEARING_Y], magy_ff[SL-1]);
      o_tx_in = rmj_pkg::pack_sat(last_side.neg[rmj_pkg::E_RATE_X], root_tx);
      o_ty_in = rmj_pkg::pack_sat(last_side.neg[rmj_pkg::E_RATE_Y], root_ty);
      if (last_side.zero) begin
         o_rx_in = '0;
         o_ry_in = '0;
         o_bx_in = '0;
         o_by_in = '0;
         o_tx_in = '0;
         o_ty_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (en) begin
         out_vld_ff <= vld_ff[BL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_rx_ff   <= o_rx_in;
         o_ry_ff   <= o_ry_in;
         o_bx_ff   <= o_bx_in;
         o_by_ff   <= o_by_in;
         o_tx_ff   <= o_tx_in;
         o_ty_ff   <= o_ty_in;
         o_zero_ff <= last_side.zero;
      end
   end

   assign rsp_valid          = out_vld_ff;
   assign rsp_range_by_px    = o_rx_ff;
   assign rsp_range_by_py    = o_ry_ff;
   assign rsp_bearing_by_px  = o_bx_ff;
   assign rsp_bearing_by_py  = o_by_ff;
   assign rsp_rate_by_px     = o_tx_ff;
   assign rsp_rate_by_py     = o_ty_ff;
   assign rsp_divide_by_zero = o_zero_ff;

endmodule

FILE: test/tb_radar_measurement_jacobian.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_radar_measurement_jacobian
// Drives predicted states into the radar Jacobian block with random idle
// gaps and result stalls. Each result is checked against a hand-written
// expectation or an exact big-integer computation of the six Jacobian entries.
// ----------------------------------------------------------------------------
module tb_radar_measurement_jacobian;

   localparam int RANDOM_ITEMS = 930;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [31:0] range_x;
      logic [31:0] range_y;
      logic [31:0] bearing_x;
      logic [31:0] bearing_y;
      logic [31:0] rate_x;
      logic [31:0] rate_y;
      logic        origin;
   } jacobian_type;

   typedef struct {
      logic [31:0]  px, py, vx, vy;
      bit           typed;
      jacobian_type want;
   } state_row_type;

   logic clock, reset;
   logic req_valid, req_ready;
   logic [31:0] req_position_x, req_position_y, req_velocity_x, req_velocity_y;
   logic rsp_valid, rsp_ready;
   logic [31:0] rsp_range_by_px, rsp_range_by_py, rsp_bearing_by_px;
   logic [31:0] rsp_bearing_by_py, rsp_rate_by_px, rsp_rate_by_py;
   logic rsp_divide_by_zero;

   jacobian_type  pending_jacobians[$];
   state_row_type directed_states[$];
   int mismatches;
   int cycles;
   int stall_left;

   radar_measurement_jacobian i_dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // largest m below 2^32 with m^2 * den <= num^2
   function automatic logic [31:0] root_quotient(input logic [511:0] num,
                                                 input logic [511:0] den);
      logic [511:0] num_sq, prod, cand;
      logic [31:0]  m;
      num_sq = num * num;
      m = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = 512'(m | (32'd1 << b));
         prod = cand * cand * den;
         if (prod <= num_sq) m = cand[31:0];
      end
      return m;
   endfunction

   function automatic logic [31:0] saturate(input bit neg, input logic [31:0] mag);
      if (neg) return mag[31] ? 32'h8000_0000 : (~mag + 32'd1);
      return mag[31] ? 32'h7FFF_FFFF : mag;
   endfunction

   function automatic jacobian_type jacobian_of(input logic [31:0] px_raw,
                                                input logic [31:0] py_raw,
                                                input logic [31:0] vx_raw,
                                                input logic [31:0] vy_raw);
      logic signed [31:0] px, py, vx, vy;
      logic signed [64:0] cross_term;
      logic [511:0] apx, apy, dmag, s, s2, s3;
      bit dneg;
      jacobian_type j;
      px = px_raw; py = py_raw; vx = vx_raw; vy = vy_raw;
      apx = px < 0 ? 512'(-64'(px)) : 512'(px);
      apy = py < 0 ? 512'(-64'(py)) : 512'(py);
      s = apx * apx + apy * apy;
      j = '0;
      if (s == 0) begin
         j.origin = 1'b1;
         return j;
      end
      s2 = s * s;
      s3 = s2 * s;
      j.range_x   = saturate(px < 0, root_quotient(apx << 16, s));
      j.range_y   = saturate(py < 0, root_quotient(apy << 16, s));
      j.bearing_x = saturate(py > 0, root_quotient(apy << 32, s2));
      j.bearing_y = saturate(px < 0, root_quotient(apx << 32, s2));
      // vx*py - vy*px, needs 65 bits signed
      cross_term = 65'(vx) * 65'(py) - 65'(vy) * 65'(px);
      dneg = cross_term < 0;
      dmag = dneg ? 512'(-cross_term) : 512'(cross_term);
      j.rate_x = saturate((py < 0) != dneg, root_quotient((apy * dmag) << 16, s3));
      j.rate_y = saturate((px < 0) == dneg, root_quotient((apx * dmag) << 16, s3));
      return j;
   endfunction

   function automatic logic [31:0] any_field();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'(int'($urandom_range(0, 64)) - 32);
         3: return 32'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
         4: return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic state_row_type row(input logic [31:0] px, py, vx, vy,
                                         input bit typed, input jacobian_type want);
      state_row_type r;
      r.px = px; r.py = py; r.vx = vx; r.vy = vy;
      r.typed = typed; r.want = want;
      return r;
   endfunction

   task automatic send_state(input logic [31:0] px, py, vx, vy,
                             input bit typed, input jacobian_type want);
      int gap;
      req_valid <= 1'b1;
      req_position_x <= px;
      req_position_y <= py;
      req_velocity_x <= vx;
      req_velocity_y <= vy;
      do @(posedge clock); while (!req_ready);
      pending_jacobians.push_back(typed ? want : jacobian_of(px, py, vx, vy));
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            ($urandom_range(0, 15) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // result side: random stalls, check against the oldest prediction
   always @(posedge clock) begin
      jacobian_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_range_by_px, rsp_range_by_py, rsp_bearing_by_px, rsp_bearing_by_py,
                rsp_rate_by_px, rsp_rate_by_py, rsp_divide_by_zero};
         if (pending_jacobians.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected item %h", got);
         end else begin
            want = pending_jacobians.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %h got %h", want, got);
            end
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
         stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60)
                                                  : $urandom_range(0, 3);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("radar_measurement_jacobian verification failed");
         $finish;
      end
   end

   initial begin
      jacobian_type w;
      mismatches = 0;
      cycles = 0;
      stall_left = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_ready = 1'b0;
      req_position_x = '0;
      req_position_y = '0;
      req_velocity_x = '0;
      req_velocity_y = '0;

      // origin
      w = '0; w.origin = 1'b1;
      directed_states.push_back(row(0, 0, 32'h1234_5678, 32'h8000_0000, 1, w));
      // unit x position
      w = '0; w.range_x = 32'h0001_0000; w.bearing_y = 32'h0001_0000;
      directed_states.push_back(row(32'h0001_0000, 0, 0, 0, 1, w));
      // smallest x step: bearing saturates
      w = '0; w.range_x = 32'h0001_0000; w.bearing_y = 32'h7FFF_FFFF;
      directed_states.push_back(row(32'h1, 0, 0, 0, 1, w));
      // smallest negative y step: bearing saturates positive
      w = '0; w.range_y = 32'hFFFF_0000; w.bearing_x = 32'h7FFF_FFFF;
      directed_states.push_back(row(0, 32'hFFFF_FFFF, 0, 0, 1, w));
      w = '0;
      directed_states.push_back(row(32'h8000_0000, 0, 0, 0, 0, w));
      directed_states.push_back(row(32'h8000_0000, 32'h8000_0000,
                                    32'h7FFF_FFFF, 32'h8000_0000, 0, w));
      directed_states.push_back(row(32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h7FFF_FFFF, 0, w));
      directed_states.push_back(row(32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, w));
      directed_states.push_back(row(32'h1, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 0, w));
      directed_states.push_back(row(32'h0003_0000, 32'h0004_0000,
                                    32'h0001_0000, 32'hFFFE_0000, 0, w));
      directed_states.push_back(row(32'hFFFD_0000, 32'hFFFC_0000,
                                    32'h0002_0000, 32'h0001_0000, 0, w));
      // velocity parallel to position: rate entries vanish
      directed_states.push_back(row(32'h0002_0000, 32'h0002_0000,
                                    32'h0005_0000, 32'h0005_0000, 0, w));
      directed_states.push_back(row(32'hFFFF_FFFF, 0, 32'h7FFF_FFFF, 32'h8000_0000, 0, w));
      directed_states.push_back(row(32'h5555_5555, 32'hAAAA_AAAA,
                                    32'hAAAA_AAAA, 32'h5555_5555, 0, w));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_states[i])
         send_state(directed_states[i].px, directed_states[i].py, directed_states[i].vx,
                    directed_states[i].vy, directed_states[i].typed, directed_states[i].want);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 2) begin
            // let the pipeline run dry once
            req_valid <= 1'b0;
            while (pending_jacobians.size() != 0) @(posedge clock);
         end
         w = '0;
         send_state(any_field(), any_field(), any_field(), any_field(), 0, w);
      end
      req_valid <= 1'b0;

      while (pending_jacobians.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("radar_measurement_jacobian verification clean");
      else
         $display("radar_measurement_jacobian verification failed");
      $finish;
   end

endmodule

FILE: sim.f
rtl/rmj_pkg.sv
rtl/rmj_div.sv
rtl/rmj_sqrt.sv
rtl/rmj_front.sv
rtl/rmj_queue.sv
rtl/rmj_back.sv
rtl/radar_measurement_jacobian.sv
test/tb_radar_measurement_jacobian.sv
